FILE: rtl/core/lmei_pkg.sv
// lmei_pkg: shared types and constants of the list-mode event indexer.
// No dependencies; used by the interfaces, the parser, the top level and the checker.
package lmei_pkg;

  localparam int BUF_HEADER_LEN    = 6;
  localparam int WORD_COUNT_OFFSET = 0;
  localparam int EVENT_HEADER_LEN  = 3;
  localparam int NUM_CHANNELS      = 4;
  localparam int MAX_BUFFER_WORDS  = 8192;

  localparam int CHAN_SLOTS = 4;
  localparam int ADDR_W     = 13;
  localparam int CNT_W      = $clog2(MAX_BUFFER_WORDS + 1);

  typedef logic [15:0]        word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [3:0]         hdr_cnt_t;
  typedef logic [2:0]         chan_t;

  typedef struct packed {
    addr_t event_index;
    word_t hit_pattern;
    chan_t active_channels;
    addr_t chan0_start;
    addr_t chan1_start;
    addr_t chan2_start;
    addr_t chan3_start;
    logic  last_in_buffer;
  } result_t;

endpackage

FILE: rtl/core/lmei_if.sv
// lmei_if: valid/ready channels of the list-mode event indexer.
// Depends on lmei_pkg for payload types.
interface lmei_in_if;
  logic              valid;
  logic              ready;
  lmei_pkg::word_t   data_word;
  logic              buffer_start;

  modport source (output valid, output data_word, output buffer_start, input ready);
  modport sink   (input valid, input data_word, input buffer_start, output ready);
  modport mon    (input valid, input data_word, input buffer_start, input ready);
endinterface

interface lmei_out_if;
  logic              valid;
  logic              ready;
  lmei_pkg::addr_t   event_index;
  lmei_pkg::word_t   hit_pattern;
  lmei_pkg::chan_t   active_channels;
  lmei_pkg::addr_t   chan0_start;
  lmei_pkg::addr_t   chan1_start;
  lmei_pkg::addr_t   chan2_start;
  lmei_pkg::addr_t   chan3_start;
  logic              last_in_buffer;

  modport source (output valid, output event_index, output hit_pattern,
                  output active_channels, output chan0_start, output chan1_start,
                  output chan2_start, output chan3_start, output last_in_buffer,
                  input ready);
  modport sink   (input valid, input event_index, input hit_pattern,
                  input active_channels, input chan0_start, input chan1_start,
                  input chan2_start, input chan3_start, input last_in_buffer,
                  output ready);
  modport mon    (input valid, input event_index, input hit_pattern,
                  input active_channels, input chan0_start, input chan1_start,
                  input chan2_start, input chan3_start, input last_in_buffer,
                  input ready);
endinterface

FILE: rtl/core/list_mode_event_indexer_unit.sv
// list_mode_event_indexer_unit: top level of the list-mode event indexer.
// Depends on lmei_pkg, lmei_in_if, lmei_out_if and lmei_parser.
//
//   channel   modport  payload                                      word
//   words     sink     data_word, buffer_start                      one buffer word
//   results   source   event_index, hit_pattern, active_channels,   one event record
//                      chan0..3_start, last_in_buffer
//
// One word per cycle while the result is not stalled: a word is registered in the
// input register, then parsed into the result register that drives the results.
// Reset clears the parse to idle; words before a buffer start are dropped.
// A stalled result holds the parser; words keep landing in the input register
// while the result register is empty or being taken.
module list_mode_event_indexer_unit (
  input  logic       clk,
  input  logic       rst,
  lmei_in_if.sink    words,
  lmei_out_if.source results
);

  logic              in_valid;
  lmei_pkg::word_t   in_word;
  logic              in_start;
  logic              advance;
  logic              res_valid;
  lmei_pkg::result_t res;
  logic              out_valid;
  lmei_pkg::result_t out_res;

  assign advance     = in_valid && (!out_valid || results.ready);
  assign words.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (words.ready) begin
      in_valid <= words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (words.ready && words.valid) begin
      in_word  <= words.data_word;
      in_start <= words.buffer_start;
    end
  end

  lmei_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_word    (in_word),
    .buffer_start (in_start),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign results.valid           = out_valid;
  assign results.event_index     = out_res.event_index;
  assign results.hit_pattern     = out_res.hit_pattern;
  assign results.active_channels = out_res.active_channels;
  assign results.chan0_start     = out_res.chan0_start;
  assign results.chan1_start     = out_res.chan1_start;
  assign results.chan2_start     = out_res.chan2_start;
  assign results.chan3_start     = out_res.chan3_start;
  assign results.last_in_buffer  = out_res.last_in_buffer;

endmodule

FILE: rtl/core/lmei_parser.sv
// lmei_parser: buffer/event/block parse state and the per-word update.
// Depends on lmei_pkg. One word is consumed on each cycle with step high.
module lmei_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lmei_pkg::word_t   data_word,
  input  logic              buffer_start,
  output logic              res_valid,
  output lmei_pkg::result_t res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BUFHDR  = 3'd1;
  localparam logic [2:0] PH_EVHDR   = 3'd2;
  localparam logic [2:0] PH_BLKLEN  = 3'd3;
  localparam logic [2:0] PH_BLKBODY = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  logic [2:0]          phase, phase_next;
  lmei_pkg::count_t    pos, pos_next;
  logic                pos_ovf, pos_ovf_next;
  lmei_pkg::count_t    count, count_next;
  lmei_pkg::hdr_cnt_t  hdr_cnt, hdr_cnt_next;
  lmei_pkg::word_t     blk_left, blk_left_next;
  lmei_pkg::chan_t     cur_ch, cur_ch_next;
  lmei_pkg::word_t     hit, hit_next;
  lmei_pkg::addr_t     evt_cnt, evt_cnt_next;
  lmei_pkg::chan_t     ch_cnt, ch_cnt_next;
  lmei_pkg::addr_t     starts [lmei_pkg::CHAN_SLOTS];
  lmei_pkg::addr_t     starts_next [lmei_pkg::CHAN_SLOTS];

  always_comb begin
    logic [2:0]          ph;
    lmei_pkg::count_t    p;
    logic                ovf;
    logic                do_adv;
    logic                do_begin;
    logic                found;
    logic                next_lt;
    logic [lmei_pkg::CNT_W:0] p_inc;
    lmei_pkg::chan_t     hit_ch;

    phase_next    = phase;
    pos_next      = pos;
    pos_ovf_next  = pos_ovf;
    count_next    = count;
    hdr_cnt_next  = hdr_cnt;
    blk_left_next = blk_left;
    cur_ch_next   = cur_ch;
    hit_next      = hit;
    evt_cnt_next  = evt_cnt;
    ch_cnt_next   = ch_cnt;
    starts_next   = starts;
    res_valid     = 1'b0;
    res           = '0;
    do_adv        = 1'b0;
    do_begin      = 1'b0;
    found         = 1'b0;
    hit_ch        = '0;

    ph  = phase;
    p   = pos;
    ovf = pos_ovf;
    if (buffer_start) begin
      p            = '0;
      ovf          = 1'b0;
      count_next   = '0;
      evt_cnt_next = '0;
      ph           = PH_BUFHDR;
      phase_next   = PH_BUFHDR;
      hdr_cnt_next = lmei_pkg::hdr_cnt_t'(lmei_pkg::BUF_HEADER_LEN);
    end

    if (!ovf && p == lmei_pkg::count_t'(lmei_pkg::WORD_COUNT_OFFSET)) begin
      if ({1'b0, data_word} > 17'(lmei_pkg::MAX_BUFFER_WORDS)) begin
        count_next = lmei_pkg::count_t'(lmei_pkg::MAX_BUFFER_WORDS);
      end else begin
        count_next = lmei_pkg::count_t'(data_word);
      end
    end

    p_inc   = {1'b0, p} + 1'b1;
    next_lt = !ovf && (p_inc < {1'b0, count_next});

    case (ph)
      PH_BUFHDR: begin
        if (hdr_cnt_next != '0) hdr_cnt_next = hdr_cnt_next - 1'b1;
        if (hdr_cnt_next == '0) do_begin = 1'b1;
      end
      PH_EVHDR: begin
        if (hdr_cnt == lmei_pkg::hdr_cnt_t'(lmei_pkg::EVENT_HEADER_LEN)) hit_next = data_word;
        if (hdr_cnt != '0) hdr_cnt_next = hdr_cnt - 1'b1;
        if (hdr_cnt_next == '0) do_adv = 1'b1;
      end
      PH_BLKLEN: begin
        starts_next[cur_ch[1:0]] = p[lmei_pkg::ADDR_W-1:0];
        ch_cnt_next = ch_cnt + 1'b1;
        blk_left_next = (data_word == '0) ? '0 : data_word - 1'b1;
        if (blk_left_next == '0) begin
          cur_ch_next = cur_ch + 1'b1;
          do_adv      = 1'b1;
        end else begin
          phase_next = PH_BLKBODY;
        end
      end
      PH_BLKBODY: begin
        if (blk_left != '0) blk_left_next = blk_left - 1'b1;
        if (blk_left_next == '0) begin
          cur_ch_next = cur_ch + 1'b1;
          do_adv      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_adv) begin
      for (int k = lmei_pkg::CHAN_SLOTS - 1; k >= 0; k--) begin
        if (k < lmei_pkg::NUM_CHANNELS && lmei_pkg::chan_t'(k) >= cur_ch_next
            && hit_next[k]) begin
          found  = 1'b1;
          hit_ch = lmei_pkg::chan_t'(k);
        end
      end
      if (found) begin
        cur_ch_next = hit_ch;
        phase_next  = PH_BLKLEN;
      end else begin
        res_valid           = 1'b1;
        res.event_index     = evt_cnt_next;
        res.hit_pattern     = hit_next;
        res.active_channels = ch_cnt_next;
        res.chan0_start     = starts_next[0];
        res.chan1_start     = starts_next[1];
        res.chan2_start     = starts_next[2];
        res.chan3_start     = starts_next[3];
        res.last_in_buffer  = !next_lt;
        evt_cnt_next        = evt_cnt_next + 1'b1;
        do_begin            = 1'b1;
      end
    end

    if (do_begin) begin
      if (next_lt) begin
        phase_next   = PH_EVHDR;
        hdr_cnt_next = lmei_pkg::hdr_cnt_t'(lmei_pkg::EVENT_HEADER_LEN);
        ch_cnt_next  = '0;
        cur_ch_next  = '0;
        hit_next     = '0;
        for (int k = 0; k < lmei_pkg::CHAN_SLOTS; k++) starts_next[k] = '0;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (ph != PH_IDLE && ph != PH_DONE) begin
      pos_next     = p + 1'b1;
      pos_ovf_next = ovf || (p == '1);
    end else begin
      pos_next     = p;
      pos_ovf_next = ovf;
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pos      <= '0;
      pos_ovf  <= 1'b0;
      count    <= '0;
      hdr_cnt  <= '0;
      blk_left <= '0;
      cur_ch   <= '0;
      hit      <= '0;
      evt_cnt  <= '0;
      ch_cnt   <= '0;
      for (int k = 0; k < lmei_pkg::CHAN_SLOTS; k++) starts[k] <= '0;
    end else if (step) begin
      phase    <= phase_next;
      pos      <= pos_next;
      pos_ovf  <= pos_ovf_next;
      count    <= count_next;
      hdr_cnt  <= hdr_cnt_next;
      blk_left <= blk_left_next;
      cur_ch   <= cur_ch_next;
      hit      <= hit_next;
      evt_cnt  <= evt_cnt_next;
      ch_cnt   <= ch_cnt_next;
      starts   <= starts_next;
    end
  end

endmodule

FILE: rtl/core/lmei_checker.sv
// lmei_checker: port-level assertions for list_mode_event_indexer_unit.
// Depends on lmei_pkg; bound to the top level below on its result channel signals.
module lmei_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input lmei_pkg::addr_t       event_index,
  input lmei_pkg::word_t       hit_pattern,
  input lmei_pkg::chan_t       active_channels,
  input lmei_pkg::addr_t       chan0_start,
  input lmei_pkg::addr_t       chan1_start,
  input lmei_pkg::addr_t       chan2_start,
  input lmei_pkg::addr_t       chan3_start
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_index)
      && $stable(hit_pattern) && $stable(chan0_start))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> active_channels ==
      3'($countones(hit_pattern[lmei_pkg::NUM_CHANNELS-1:0])))
    else $error("active channel count does not match hit pattern");

  a_idle_start: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (hit_pattern[0] || chan0_start == '0)
      && (hit_pattern[1] || chan1_start == '0)
      && (hit_pattern[2] || chan2_start == '0)
      && (hit_pattern[3] || chan3_start == '0))
    else $error("inactive channel has a start address");

endmodule

bind list_mode_event_indexer_unit lmei_checker u_lmei_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (results.valid),
  .res_ready       (results.ready),
  .event_index     (results.event_index),
  .hit_pattern     (results.hit_pattern),
  .active_channels (results.active_channels),
  .chan0_start     (results.chan0_start),
  .chan1_start     (results.chan1_start),
  .chan2_start     (results.chan2_start),
  .chan3_start     (results.chan3_start)
);
